// ----- sv/mse_pkg.sv -----
// Shared types and constants for the multi-segment envelope unit.
package mse_pkg;

    localparam int MAX_SEGMENTS_DEF = 4;
    localparam int SEG_REGS         = 4;
    localparam int CFG_ADDR_W       = 6;
    localparam int CFG_DATA_W       = 64;
    localparam int COUNT_W          = 3;
    localparam int SEG_WORD_W       = 50;

    localparam logic [23:0] ONE_Q21 = 24'h200000;
    localparam logic [23:0] EPS_Q21 = 24'd2097;

    typedef enum logic [1:0] {
        REQ_SAMPLE  = 2'd0,
        REQ_TRIGGER = 2'd1,
        REQ_RELEASE = 2'd2
    } req_t;

    typedef enum logic [1:0] {
        KIND_FLAT = 2'd0,
        KIND_LIN  = 2'd1,
        KIND_EXP  = 2'd2
    } kind_t;

    typedef enum logic [2:0] {
        REG_COUNT = 3'd0,
        REG_SEG0  = 3'd1,
        REG_SEG1  = 3'd2,
        REG_SEG2  = 3'd3,
        REG_SEG3  = 3'd4
    } reg_idx_t;

    typedef struct packed {
        logic [1:0]         kind;
        logic signed [23:0] target;
        logic [23:0]        low;
    } seg_t;

endpackage

// ----- sv/mse_cfg.sv -----
// APB register file holding the segment count and the segment words.
module mse_cfg #(
    parameter int MAX_SEGMENTS = mse_pkg::MAX_SEGMENTS_DEF,
    parameter int CNT_W        = $clog2(MAX_SEGMENTS + 1)
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [mse_pkg::CFG_ADDR_W-1:0] paddr,
    input  logic [mse_pkg::CFG_DATA_W-1:0] pwdata,
    output logic [mse_pkg::CFG_DATA_W-1:0] prdata,
    output logic                          pready,
    output mse_pkg::seg_t                 segs [MAX_SEGMENTS],
    output logic [CNT_W-1:0]              used_cnt
);

    localparam int NUM_STORED = (MAX_SEGMENTS < mse_pkg::SEG_REGS) ?
                                MAX_SEGMENTS : mse_pkg::SEG_REGS;

    logic [mse_pkg::COUNT_W-1:0]    count_reg;
    logic [mse_pkg::SEG_WORD_W-1:0] seg_word_reg [NUM_STORED];
    logic [2:0]                     reg_sel;
    logic                           wr_en;

    assign pready  = 1'b1;
    assign reg_sel = paddr[5:3];
    assign wr_en   = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= 3'd2;
            for (int i = 0; i < NUM_STORED; i++)
            begin
                seg_word_reg[i] <= '0;
            end
        end
        else if (wr_en)
        begin
            if (reg_sel == mse_pkg::REG_COUNT)
            begin
                count_reg <= pwdata[mse_pkg::COUNT_W-1:0];
            end
            for (int i = 0; i < NUM_STORED; i++)
            begin
                if (reg_sel == 3'(int'(mse_pkg::REG_SEG0) + i))
                begin
                    seg_word_reg[i] <= pwdata[mse_pkg::SEG_WORD_W-1:0];
                end
            end
        end
    end

    always_comb
    begin
        prdata = '0;
        if (reg_sel == mse_pkg::REG_COUNT)
        begin
            prdata = mse_pkg::CFG_DATA_W'(count_reg);
        end
        for (int i = 0; i < NUM_STORED; i++)
        begin
            if (reg_sel == 3'(int'(mse_pkg::REG_SEG0) + i))
            begin
                prdata = mse_pkg::CFG_DATA_W'(seg_word_reg[i]);
            end
        end
    end

    // segments past the stored words are flat at zero
    always_comb
    begin
        for (int i = 0; i < MAX_SEGMENTS; i++)
        begin
            if (i < NUM_STORED)
            begin
                segs[i] = mse_pkg::seg_t'(seg_word_reg[i]);
            end
            else
            begin
                segs[i] = '0;
            end
        end
    end

    always_comb
    begin
        if (count_reg < 3'd2)
        begin
            used_cnt = CNT_W'(2);
        end
        else if (count_reg > 3'(MAX_SEGMENTS))
        begin
            used_cnt = CNT_W'(MAX_SEGMENTS);
        end
        else
        begin
            used_cnt = CNT_W'(count_reg);
        end
    end

endmodule

// ----- sv/multi_segment_envelope_unit.sv -----
// Top level of the multi-segment envelope unit: input stage, step logic, result stage.
//
//   channel   direction  handshake            word
//   request   in         req_valid/req_stall  req_type, sample_in
//   result    out        res_valid/res_stall  sample_out, env_level, active
//   config    in         APB psel/penable     segment_count, segment_word_0..3
//
// One word per cycle sustained while the result is not stalled; a word is held in the input register and then
// enters the result register, from which its result is offered.
// The envelope state updates in the same cycle the word enters the result register.
// A stalled result holds the result register and then the input register.
// Reset clears control and envelope state: level zero, base one, idle.
module multi_segment_envelope_unit #(
    parameter int MAX_SEGMENTS = mse_pkg::MAX_SEGMENTS_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          req_valid,
    output logic                          req_stall,
    input  logic [1:0]                    req_type,
    input  logic signed [23:0]            sample_in,
    output logic                          res_valid,
    input  logic                          res_stall,
    output logic signed [23:0]            sample_out,
    output logic signed [23:0]            env_level,
    output logic                          active,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [mse_pkg::CFG_ADDR_W-1:0] paddr,
    input  logic [mse_pkg::CFG_DATA_W-1:0] pwdata,
    output logic [mse_pkg::CFG_DATA_W-1:0] prdata,
    output logic                          pready
);

    localparam int CNT_W = $clog2(MAX_SEGMENTS + 1);
    localparam int IDX_W = (MAX_SEGMENTS > 1) ? $clog2(MAX_SEGMENTS) : 1;

    mse_pkg::seg_t     segs [MAX_SEGMENTS];
    logic [CNT_W-1:0]  used_cnt;

    // input stage
    logic                s1_valid_reg;
    mse_pkg::req_t       s1_req_reg;
    logic signed [23:0]  s1_sample_reg;

    // envelope state
    logic signed [23:0]  level_reg;
    logic [23:0]         base_reg;
    logic [IDX_W-1:0]    idx_reg;
    logic                run_reg;
    logic signed [23:0]  level_next;
    logic [23:0]         base_next;
    logic [IDX_W-1:0]    idx_next;
    logic                run_next;

    // result stage
    logic                res_valid_reg;
    logic signed [23:0]  sample_out_reg;
    logic signed [23:0]  env_level_reg;
    logic                active_reg;

    logic                out_ready;
    logic                s1_fire;

    // step datapath
    mse_pkg::seg_t       seg_cur;
    logic signed [47:0]  smul;
    logic signed [47:0]  smul_rnd;
    logic signed [23:0]  sout;
    logic [47:0]         emul;
    logic [47:0]         emul_rnd;
    logic [26:0]         eq;
    logic [23:0]         upd_base;
    logic signed [26:0]  lin_sum;
    logic signed [26:0]  rise_sum;
    logic signed [26:0]  fall_sum;
    logic signed [24:0]  fall_lim;
    logic signed [23:0]  upd_lvl;
    logic                upd_end;
    logic [CNT_W-1:0]    next_cnt;

    logic [IDX_W-1:0]    ent_idx;
    logic signed [23:0]  ent_lvl;
    mse_pkg::seg_t       seg_ent;
    logic [23:0]         ent_base;

    function automatic logic signed [23:0] sat24(input logic signed [26:0] v);
        if (v > 27'sd8388607)
        begin
            return 24'sh7FFFFF;
        end
        else if (v < -27'sd8388608)
        begin
            return 24'sh800000;
        end
        return v[23:0];
    endfunction

    function automatic logic [23:0] clamp_base(input logic signed [26:0] v);
        if (v < 27'sd1)
        begin
            return 24'd1;
        end
        else if (v > 27'sd16777215)
        begin
            return 24'hFFFFFF;
        end
        return v[23:0];
    endfunction

    mse_cfg #(
        .MAX_SEGMENTS (MAX_SEGMENTS),
        .CNT_W        (CNT_W)
    ) u_cfg (
        .clk      (clk),
        .rst_n    (rst_n),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready),
        .segs     (segs),
        .used_cnt (used_cnt)
    );

    assign out_ready = !res_valid_reg || !res_stall;
    assign s1_fire   = s1_valid_reg && out_ready;
    assign req_stall = s1_valid_reg && !out_ready;

    assign res_valid  = res_valid_reg;
    assign sample_out = sample_out_reg;
    assign env_level  = env_level_reg;
    assign active     = active_reg;

    // level update for one sample in the current segment
    assign seg_cur  = segs[idx_reg];
    assign smul     = s1_sample_reg * level_reg;
    assign smul_rnd = smul + 48'sd1048576;
    assign sout     = sat24(smul_rnd[47:21]);

    assign emul     = base_reg * seg_cur.low;
    assign emul_rnd = emul + 48'd1048576;
    assign eq       = emul_rnd[47:21];

    always_comb
    begin
        if (eq == 27'd0)
        begin
            upd_base = 24'd1;
        end
        else if (|eq[26:24])
        begin
            upd_base = 24'hFFFFFF;
        end
        else
        begin
            upd_base = eq[23:0];
        end
    end

    assign lin_sum  = 27'(level_reg) + 27'($signed(seg_cur.low));
    assign rise_sum = $signed({3'b000, upd_base}) - $signed({3'b000, mse_pkg::ONE_Q21});
    assign fall_sum = $signed({3'b000, upd_base}) + 27'(seg_cur.target);
    assign fall_lim = 25'(seg_cur.target) + $signed({1'b0, mse_pkg::EPS_Q21});

    always_comb
    begin
        case (seg_cur.kind)
            mse_pkg::KIND_EXP:
            begin
                if (seg_cur.low > mse_pkg::ONE_Q21)
                begin
                    upd_lvl = sat24(rise_sum);
                    upd_end = upd_lvl >= seg_cur.target;
                end
                else
                begin
                    upd_lvl = sat24(fall_sum);
                    upd_end = 25'(upd_lvl) <= fall_lim;
                end
            end
            mse_pkg::KIND_LIN:
            begin
                upd_lvl = sat24(lin_sum);
                if ($signed(seg_cur.low) > 24'sd0)
                begin
                    upd_end = upd_lvl >= seg_cur.target;
                end
                else
                begin
                    upd_end = upd_lvl <= seg_cur.target;
                end
            end
            default:
            begin
                upd_lvl = seg_cur.target;
                upd_end = 1'b0;
            end
        endcase
    end

    assign next_cnt = CNT_W'(idx_reg) + CNT_W'(1);

    // base on entry to a segment
    always_comb
    begin
        case (s1_req_reg)
            mse_pkg::REQ_TRIGGER:
            begin
                ent_idx = '0;
                ent_lvl = level_reg;
            end
            mse_pkg::REQ_RELEASE:
            begin
                ent_idx = IDX_W'(used_cnt - CNT_W'(1));
                ent_lvl = level_reg;
            end
            default:
            begin
                ent_idx = IDX_W'(next_cnt);
                ent_lvl = upd_lvl;
            end
        endcase
    end

    assign seg_ent = segs[ent_idx];

    always_comb
    begin
        if (seg_ent.kind == mse_pkg::KIND_EXP)
        begin
            if (seg_ent.low > mse_pkg::ONE_Q21)
            begin
                ent_base = clamp_base(27'(ent_lvl) + $signed({3'b000, mse_pkg::ONE_Q21}));
            end
            else
            begin
                ent_base = clamp_base(27'(ent_lvl) - 27'(seg_ent.target));
            end
        end
        else
        begin
            ent_base = mse_pkg::ONE_Q21;
        end
    end

    always_comb
    begin
        level_next = level_reg;
        base_next  = base_reg;
        idx_next   = idx_reg;
        run_next   = run_reg;
        case (s1_req_reg)
            mse_pkg::REQ_SAMPLE:
            begin
                if (run_reg)
                begin
                    level_next = upd_lvl;
                    if (seg_cur.kind == mse_pkg::KIND_EXP)
                    begin
                        base_next = upd_base;
                    end
                    if (upd_end)
                    begin
                        if (next_cnt >= used_cnt)
                        begin
                            run_next = 1'b0;
                            idx_next = '0;
                        end
                        else
                        begin
                            idx_next  = ent_idx;
                            base_next = ent_base;
                        end
                    end
                end
            end
            mse_pkg::REQ_TRIGGER:
            begin
                idx_next = '0;
                run_next = 1'b1;
                if (run_reg)
                begin
                    base_next = ent_base;
                end
                else
                begin
                    base_next = mse_pkg::ONE_Q21;
                end
            end
            mse_pkg::REQ_RELEASE:
            begin
                idx_next  = ent_idx;
                run_next  = 1'b1;
                base_next = ent_base;
            end
            default:
            begin
                level_next = level_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            res_valid_reg <= 1'b0;
            level_reg     <= '0;
            base_reg      <= mse_pkg::ONE_Q21;
            idx_reg       <= '0;
            run_reg       <= 1'b0;
        end
        else
        begin
            if (!s1_valid_reg || out_ready)
            begin
                s1_valid_reg <= req_valid;
            end
            if (out_ready)
            begin
                res_valid_reg <= s1_valid_reg;
            end
            if (s1_fire)
            begin
                level_reg <= level_next;
                base_reg  <= base_next;
                idx_reg   <= idx_next;
                run_reg   <= run_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (req_valid && !req_stall)
        begin
            s1_req_reg    <= mse_pkg::req_t'(req_type);
            s1_sample_reg <= sample_in;
        end
        if (s1_fire)
        begin
            sample_out_reg <= (s1_req_reg == mse_pkg::REQ_SAMPLE && run_reg) ? sout : '0;
            env_level_reg  <= level_next;
            active_reg     <= run_next;
        end
    end

endmodule

// ----- bench/tb_top.sv -----
// Self-checking testbench for multi_segment_envelope_unit: directed and random words, APB setup.
module tb_top;

    localparam logic [1:0] REQ_UNUSED  = 2'd3;
    localparam logic [1:0] KIND_SPARE  = 2'd3;
    localparam int         CYCLE_LIMIT = 300000;
    localparam int         SETTLE      = 6;
    localparam longint     ONE         = 2097152;
    localparam longint     EPS         = 2097;

    typedef struct {
        logic signed [23:0] scaled;
        logic signed [23:0] level;
        logic               active;
    } envelope_out_t;

    class envelope_scoreboard;
        logic [2:0]         count_reg;
        logic [49:0]        seg_word [mse_pkg::MAX_SEGMENTS_DEF];
        logic signed [23:0] level;
        logic [23:0]        base;
        int                 seg_idx;
        bit                 running;
        envelope_out_t      outputs_due [$];
        int                 mismatches;

        function new();
            count_reg = 3'd2;
            foreach (seg_word[i]) seg_word[i] = '0;
            level = '0;
            base = mse_pkg::ONE_Q21;
            seg_idx = 0;
            running = 1'b0;
            mismatches = 0;
        endfunction

        function void write_register(mse_pkg::reg_idx_t idx, logic [63:0] value);
            if (idx == mse_pkg::REG_COUNT)
                count_reg = value[2:0];
            else
                seg_word[int'(idx) - 1] = value[49:0];
        endfunction

        function logic signed [23:0] saturate(longint v);
            if (v > 8388607) return 24'sh7FFFFF;
            if (v < -8388608) return 24'sh800000;
            return v[23:0];
        endfunction

        function logic [23:0] clamp_base(longint v);
            if (v < 1) return 24'd1;
            if (v > 16777215) return 24'hFFFFFF;
            return v[23:0];
        endfunction

        function longint round_mul(longint a, longint b);
            return (a * b + 1048576) >>> 21;
        endfunction

        function int segments_in_use();
            if (count_reg < 2) return 2;
            if (count_reg > mse_pkg::MAX_SEGMENTS_DEF) return mse_pkg::MAX_SEGMENTS_DEF;
            return int'(count_reg);
        endfunction

        function void enter_segment(int i);
            logic signed [23:0] tgt;
            logic [23:0]        low;
            tgt = seg_word[i][47:24];
            low = seg_word[i][23:0];
            if (seg_word[i][49:48] == mse_pkg::KIND_EXP) begin
                if (low > mse_pkg::ONE_Q21)
                    base = clamp_base(longint'(level) + ONE);
                else
                    base = clamp_base(longint'(level) - longint'(tgt));
            end else begin
                base = mse_pkg::ONE_Q21;
            end
        endfunction

        function void next_segment();
            if (seg_idx + 1 >= segments_in_use()) begin
                running = 1'b0;
                seg_idx = 0;
            end else begin
                seg_idx = seg_idx + 1;
                enter_segment(seg_idx);
            end
        endfunction

        function void update_level();
            int                 i;
            logic [1:0]         kind;
            logic signed [23:0] tgt;
            logic [23:0]        low;
            logic signed [23:0] step;
            longint             prod;
            i = seg_idx % mse_pkg::MAX_SEGMENTS_DEF;
            kind = seg_word[i][49:48];
            tgt = seg_word[i][47:24];
            low = seg_word[i][23:0];
            step = low;
            if (kind == mse_pkg::KIND_EXP) begin
                prod = (longint'(base) * longint'(low) + 1048576) >>> 21;
                base = clamp_base(prod);
                if (low > mse_pkg::ONE_Q21) begin
                    level = saturate(longint'(base) - ONE);
                    if (level >= tgt) next_segment();
                end else begin
                    level = saturate(longint'(base) + longint'(tgt));
                    if (longint'(level) <= longint'(tgt) + EPS) next_segment();
                end
            end else if (kind == mse_pkg::KIND_LIN) begin
                level = saturate(longint'(level) + longint'(step));
                if (step > 0) begin
                    if (level >= tgt) next_segment();
                end else begin
                    if (level <= tgt) next_segment();
                end
            end else begin
                level = tgt;
            end
        endfunction

        function void note_request(logic [1:0] req, logic signed [23:0] sample);
            envelope_out_t out;
            bit            was_idle;
            out.scaled = '0;
            case (req)
                mse_pkg::REQ_SAMPLE: begin
                    if (running) begin
                        out.scaled = saturate(round_mul(longint'(sample), longint'(level)));
                        update_level();
                    end
                end
                mse_pkg::REQ_TRIGGER: begin
                    was_idle = !running;
                    seg_idx = 0;
                    running = 1'b1;
                    if (was_idle) base = mse_pkg::ONE_Q21;
                    else enter_segment(0);
                end
                mse_pkg::REQ_RELEASE: begin
                    seg_idx = segments_in_use() - 1;
                    running = 1'b1;
                    enter_segment(seg_idx);
                end
                default: ;
            endcase
            out.level = level;
            out.active = running;
            outputs_due.push_back(out);
        endfunction

        function void check_result(logic signed [23:0] scaled, logic signed [23:0] lvl,
                                   logic act);
            envelope_out_t want;
            if (outputs_due.size() == 0) begin
                $error("unexpected word: sample_out %0d env_level %0d active %0b",
                       scaled, lvl, act);
                mismatches++;
                return;
            end
            want = outputs_due.pop_front();
            if (scaled !== want.scaled) begin
                $error("sample_out: expected %0d, got %0d", want.scaled, scaled);
                mismatches++;
            end
            if (lvl !== want.level) begin
                $error("env_level: expected %0d, got %0d", want.level, lvl);
                mismatches++;
            end
            if (act !== want.active) begin
                $error("active: expected %0b, got %0b", want.active, act);
                mismatches++;
            end
        endfunction
    endclass

    logic                           clk = 1'b0;
    logic                           rst_n;
    logic                           req_valid;
    logic                           req_stall;
    logic [1:0]                     req_type;
    logic signed [23:0]             sample_in;
    logic                           res_valid;
    logic                           res_stall;
    logic signed [23:0]             sample_out;
    logic signed [23:0]             env_level;
    logic                           active;
    logic                           psel;
    logic                           penable;
    logic                           pwrite;
    logic [mse_pkg::CFG_ADDR_W-1:0] paddr;
    logic [mse_pkg::CFG_DATA_W-1:0] pwdata;
    logic [mse_pkg::CFG_DATA_W-1:0] prdata;
    logic                           pready;

    envelope_scoreboard env_model;
    bit                 quiet_tx;
    bit                 quiet_rx;
    int                 cycles = 0;

    multi_segment_envelope_unit DUT (
        .clk        (clk),
        .rst_n      (rst_n),
        .req_valid  (req_valid),
        .req_stall  (req_stall),
        .req_type   (req_type),
        .sample_in  (sample_in),
        .res_valid  (res_valid),
        .res_stall  (res_stall),
        .sample_out (sample_out),
        .env_level  (env_level),
        .active     (active),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT)
        begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n === 1'b1)
        begin
            if (req_valid && !req_stall) env_model.note_request(req_type, sample_in);
            if (res_valid && !res_stall) env_model.check_result(sample_out, env_level, active);
        end
    end

    initial
    begin
        int hold;
        res_stall = 1'b0;
        @(posedge rst_n);
        @(negedge clk);
        forever
        begin
            hold = quiet_rx ? 0 : $urandom_range(0, 17);
            if (hold > 0)
            begin
                res_stall = 1'b1;
                repeat (hold) @(negedge clk);
                res_stall = 1'b0;
            end
            do @(posedge clk); while (!res_valid);
            @(negedge clk);
        end
    end

    task automatic send_word(input logic [1:0] req, input logic [23:0] value);
        int gap;
        gap = quiet_tx ? 0 : $urandom_range(0, 17);
        if (gap > 0)
        begin
            req_valid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        req_valid = 1'b1;
        req_type = req;
        sample_in = value;
        do @(posedge clk); while (req_stall);
        @(negedge clk);
    endtask

    task automatic drain_results();
        req_valid = 1'b0;
        while (env_model.outputs_due.size() != 0) @(negedge clk);
        repeat (SETTLE) @(negedge clk);
    endtask

    task automatic write_register(input mse_pkg::reg_idx_t idx, input logic [63:0] value);
        psel = 1'b1;
        penable = 1'b0;
        pwrite = 1'b1;
        paddr = {idx, 3'b000};
        pwdata = value;
        @(negedge clk);
        penable = 1'b1;
        do @(posedge clk); while (!pready);
        @(negedge clk);
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        env_model.write_register(idx, value);
    endtask

    task automatic configure(input logic [2:0] count, input logic [49:0] s0,
                             input logic [49:0] s1, input logic [49:0] s2,
                             input logic [49:0] s3);
        write_register(mse_pkg::REG_COUNT, 64'(count));
        write_register(mse_pkg::REG_SEG0, 64'(s0));
        write_register(mse_pkg::REG_SEG1, 64'(s1));
        write_register(mse_pkg::REG_SEG2, 64'(s2));
        write_register(mse_pkg::REG_SEG3, 64'(s3));
    endtask

    function automatic logic [23:0] pick_sample();
        case ($urandom_range(0, 9))
            0: return 24'h7FFFFF;
            1: return 24'h800000;
            2: return 24'h000000;
            default: return 24'($urandom());
        endcase
    endfunction

    function automatic logic [49:0] random_segment();
        logic [1:0]  kind;
        logic [23:0] tgt;
        logic [23:0] low;
        tgt = 24'($urandom());
        low = 24'($urandom());
        kind = mse_pkg::KIND_FLAT;
        case ($urandom_range(0, 9))
            0: kind = 2'($urandom_range(0, 3));
            1, 2, 3:
            begin
                kind = mse_pkg::KIND_LIN;
                low = 24'($urandom_range(1, 1 << $urandom_range(4, 22)));
                if ($urandom_range(0, 1)) low = -low;
            end
            4, 5, 6:
            begin
                kind = mse_pkg::KIND_EXP;
                tgt = 24'($urandom_range(0, 1 << 23)) - 24'h400000;
                if ($urandom_range(0, 1))
                    low = mse_pkg::ONE_Q21 + 24'($urandom_range(1, 1 << 18));
                else
                    low = mse_pkg::ONE_Q21 - 24'($urandom_range(0, 1 << 20));
            end
            7: kind = mse_pkg::KIND_FLAT;
            8: kind = KIND_SPARE;
            default:
            begin
                kind = mse_pkg::KIND_EXP;
                low = $urandom_range(0, 1) ? 24'hFFFFFF : 24'h000000;
            end
        endcase
        return {kind, tgt, low};
    endfunction

    task automatic run_random_phase(input logic [2:0] count, input int quota);
        int sent;
        int n;
        bit paused;
        configure(count, random_segment(), random_segment(), random_segment(),
                  random_segment());
        sent = 0;
        paused = 1'b0;
        while (sent < quota)
        begin
            quiet_tx = ($urandom_range(0, 3) == 0);
            quiet_rx = ($urandom_range(0, 3) == 0);
            if ($urandom_range(0, 6) != 0)
            begin
                send_word(mse_pkg::REQ_TRIGGER, pick_sample());
                n = $urandom_range(4, 40);
                repeat (n) send_word(mse_pkg::REQ_SAMPLE, pick_sample());
                sent += n + 1;
                if ($urandom_range(0, 1))
                begin
                    send_word(mse_pkg::REQ_RELEASE, pick_sample());
                    n = $urandom_range(2, 20);
                    repeat (n) send_word(mse_pkg::REQ_SAMPLE, pick_sample());
                    sent += n + 1;
                end
            end
            else
            begin
                n = $urandom_range(1, 6);
                repeat (n) send_word(2'($urandom_range(0, 3)), pick_sample());
                sent += n;
            end
            if (!paused && sent > quota / 2)
            begin
                drain_results();
                paused = 1'b1;
            end
        end
        drain_results();
    endtask

    initial
    begin
        logic [2:0] phase_counts [7];
        rst_n = 1'b0;
        req_valid = 1'b0;
        req_type = mse_pkg::REQ_SAMPLE;
        sample_in = '0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        quiet_tx = 1'b0;
        quiet_rx = 1'b0;
        phase_counts = '{3'd1, 3'd4, 3'd0, 3'd2, 3'd5, 3'd3, 3'd7};
        env_model = new();
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        repeat (2) @(negedge clk);

        // linear rise, fast exponential fall, zero-step last segment
        configure(3'd3, {mse_pkg::KIND_LIN, 24'h300000, 24'h180000},
                  {mse_pkg::KIND_EXP, 24'h080000, 24'h040000},
                  {mse_pkg::KIND_LIN, 24'h7FFFFF, 24'h000000},
                  {mse_pkg::KIND_FLAT, 24'h000000, 24'h000000});
        send_word(mse_pkg::REQ_SAMPLE, 24'h7FFFFF);
        send_word(mse_pkg::REQ_RELEASE, 24'h000000);
        send_word(mse_pkg::REQ_SAMPLE, 24'hFFFFFF);
        send_word(mse_pkg::REQ_TRIGGER, 24'h000000);
        send_word(mse_pkg::REQ_SAMPLE, 24'h7FFFFF);
        send_word(mse_pkg::REQ_SAMPLE, 24'h800000);
        send_word(mse_pkg::REQ_SAMPLE, 24'h7FFFFF);
        send_word(mse_pkg::REQ_SAMPLE, 24'h800000);
        send_word(mse_pkg::REQ_SAMPLE, 24'h000000);
        send_word(mse_pkg::REQ_SAMPLE, 24'h000001);
        send_word(mse_pkg::REQ_TRIGGER, 24'h000000);
        send_word(REQ_UNUSED, 24'h555555);
        send_word(mse_pkg::REQ_SAMPLE, 24'hAAAAAA);
        send_word(mse_pkg::REQ_RELEASE, 24'h000000);
        send_word(mse_pkg::REQ_SAMPLE, 24'h123456);
        send_word(mse_pkg::REQ_SAMPLE, 24'h7FFFFF);
        drain_results();

        // count above range, exponential extremes, spare kind as last segment
        configure(3'd7, {mse_pkg::KIND_LIN, 24'h000000, 24'h7FFFFF},
                  {mse_pkg::KIND_EXP, 24'h7FFFFF, 24'hFFFFFF},
                  {mse_pkg::KIND_EXP, 24'h800000, 24'h000000},
                  {KIND_SPARE, 24'h800000, 24'hFFFFFF});
        send_word(mse_pkg::REQ_TRIGGER, 24'h000000);
        send_word(mse_pkg::REQ_SAMPLE, 24'h7FFFFF);
        send_word(mse_pkg::REQ_SAMPLE, 24'h800000);
        send_word(mse_pkg::REQ_SAMPLE, 24'h7FFFFF);
        send_word(mse_pkg::REQ_SAMPLE, 24'h000001);
        send_word(mse_pkg::REQ_SAMPLE, 24'h7FFFFF);
        send_word(mse_pkg::REQ_RELEASE, 24'h000000);
        send_word(mse_pkg::REQ_SAMPLE, 24'h800000);
        send_word(mse_pkg::REQ_TRIGGER, 24'h000000);
        drain_results();

        foreach (phase_counts[p]) run_random_phase(phase_counts[p], 100);

        if (env_model.mismatches == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
